@@ hw/rtl/rtpl_pkg.sv @@
// ----------------------------------------------------------------------------
// rtpl_pkg
// Shared types, widths and codes for the region table point lookup unit.
// ----------------------------------------------------------------------------
package rtpl_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int LAT_W       = 30;
    localparam int LON_W       = 31;
    localparam int OUT_IDX_W   = 5;
    localparam int ENTRY_W     = 2 * LAT_W + 2 * LON_W;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HINT,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
    } point_t;

    typedef struct packed {
        logic [LAT_W-1:0] min_lat;
        logic [LAT_W-1:0] max_lat;
        logic [LON_W-1:0] min_lon;
        logic [LON_W-1:0] max_lon;
    } entry_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] index;
        logic                 full;
    } result_t;

    // RAM port towards the table memory
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
        entry_t           wdata;
    } ram_req_t;

    // Keep the low bits of an entry index for the result word
    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] v);
        logic [IDX_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, v};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

@@ hw/rtl/region_table_point_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// region_table_point_lookup_unit
// Rectangle table with hinted point lookup, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  s_      | in  | s_valid / s_ready  | command, point, rectangle
//  m_      | out | m_valid / m_ready  | found, entry_index, table_full
//
//  An append goes from accept straight to the done state; a lookup first
//  tests the hint entry and ends there on a hint hit or an empty table, else
//  it scans from entry 0 until a match or the last entry, one read at a time
//  through the single read port of the table RAM.
//  Reset clears the entry count and the hint; table contents are not cleared.
//  A result waits in the output register while the next word is accepted;
//  a stalled output holds the sequencer once a second result is ready.
// ----------------------------------------------------------------------------
module region_table_point_lookup_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic signed [rtpl_pkg::LAT_W-1:0] s_point_lat,
    input  logic signed [rtpl_pkg::LON_W-1:0] s_point_lon,
    input  logic signed [rtpl_pkg::LAT_W-1:0] s_rect_min_lat,
    input  logic signed [rtpl_pkg::LAT_W-1:0] s_rect_max_lat,
    input  logic signed [rtpl_pkg::LON_W-1:0] s_rect_min_lon,
    input  logic signed [rtpl_pkg::LON_W-1:0] s_rect_max_lon,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic [rtpl_pkg::OUT_IDX_W-1:0] m_entry_index,
    output logic                           m_table_full
);
    import rtpl_pkg::*;

    point_t           s_point;
    entry_t           s_rect;
    result_t          m_result;
    ram_req_t         ram_req;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t           rd_entry;
    point_t           cmp_point;
    logic             cmp_hit;

    assign s_point = '{lat: s_point_lat, lon: s_point_lon};
    assign s_rect  = '{min_lat: s_rect_min_lat, max_lat: s_rect_max_lat,
                       min_lon: s_rect_min_lon, max_lon: s_rect_max_lon};
    assign rd_entry = ram_rdata;

    rtpl_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_point   (s_point),
        .s_rect    (s_rect),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .ram_req   (ram_req),
        .cmp_point (cmp_point),
        .cmp_hit   (cmp_hit)
    );

    rtpl_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    rtpl_match u_match (
        .pt    (cmp_point),
        .entry (rd_entry),
        .hit   (cmp_hit)
    );

    assign m_found       = m_result.found;
    assign m_entry_index = m_result.index;
    assign m_table_full  = m_result.full;

`ifndef SYNTH
    // one word in flight: the input closes right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in progress");

    // the table is written only by an accepted append
    a_write_on_append: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.we |-> (s_valid && s_ready && (s_command == CMD_APPEND)))
        else $error("table write without an accepted append");

    // a rejected append never reports a match
    a_full_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_table_full))
        else $error("result flags both found and table full");
`endif

endmodule

@@ hw/rtl/rtpl_ram.sv @@
// ----------------------------------------------------------------------------
// rtpl_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module rtpl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/rtpl_match.sv @@
// ----------------------------------------------------------------------------
// rtpl_match
// Inclusive point-in-rectangle test of one table entry.
// ----------------------------------------------------------------------------
module rtpl_match (
    input  rtpl_pkg::point_t pt,
    input  rtpl_pkg::entry_t entry,
    output logic             hit
);
    import rtpl_pkg::*;

    logic lat_ok;
    logic lon_ok;

    assign lat_ok = ($signed(pt.lat) >= $signed(entry.min_lat)) &&
                    ($signed(pt.lat) <= $signed(entry.max_lat));
    assign lon_ok = ($signed(pt.lon) >= $signed(entry.min_lon)) &&
                    ($signed(pt.lon) <= $signed(entry.max_lon));
    assign hit    = lat_ok && lon_ok;

endmodule

@@ hw/rtl/rtpl_seq.sv @@
// ----------------------------------------------------------------------------
// rtpl_seq
// Sequencer: appends entries, tests the hint, scans the table one entry a
// cycle and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module rtpl_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  rtpl_pkg::point_t                  s_point,
    input  rtpl_pkg::entry_t                  s_rect,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rtpl_pkg::result_t                 m_result,
    output rtpl_pkg::ram_req_t                ram_req,
    output rtpl_pkg::point_t                  cmp_point,
    input  logic                              cmp_hit
);
    import rtpl_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     hint_reg, hint_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    point_t               pt_reg, pt_next;
    result_t              res_reg, res_next;
    result_t              out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 accept;
    logic                 out_load;
    logic                 hint_hit;
    logic                 scan_last;
    logic [CNT_W-1:0]     scan_inc;
    result_t              miss;

    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);
    assign hint_hit  = cmp_hit && ({1'b0, hint_reg} < count_reg);
    assign scan_inc  = {1'b0, scan_reg} + CNT_W'(1);
    assign scan_last = scan_inc >= count_reg;
    assign miss      = '{found: 1'b0, index: '0, full: 1'b0};
    assign cmp_point = pt_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_command == CMD_LOOKUP) ? ST_HINT : ST_DONE;
                end
            end
            ST_HINT: begin
                if (hint_hit || (count_reg == '0)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmp_hit || scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_ready        = 1'b0;
        count_next     = count_reg;
        hint_next      = hint_reg;
        scan_next      = scan_reg;
        pt_next        = pt_reg;
        res_next       = res_reg;
        ram_req.we     = 1'b0;
        ram_req.waddr  = count_reg[IDX_W-1:0];
        ram_req.wdata  = s_rect;
        ram_req.raddr  = hint_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (s_command == CMD_LOOKUP) begin
                        pt_next = s_point;
                    end else if (count_reg >= CNT_W'(MAX_ENTRIES)) begin
                        res_next = '{found: 1'b0, index: '0, full: 1'b1};
                    end else begin
                        ram_req.we = 1'b1;
                        res_next   = '{found: 1'b0,
                                       index: to_out_idx(count_reg[IDX_W-1:0]),
                                       full:  1'b0};
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_HINT: begin
                // fetch entry 0 in case the hint misses
                ram_req.raddr = '0;
                scan_next     = '0;
                if (hint_hit) begin
                    res_next = '{found: 1'b1, index: to_out_idx(hint_reg), full: 1'b0};
                end else begin
                    hint_next = '0;
                    res_next  = miss;
                end
            end
            ST_SCAN: begin
                ram_req.raddr = scan_inc[IDX_W-1:0];
                if (cmp_hit) begin
                    res_next  = '{found: 1'b1, index: to_out_idx(scan_reg), full: 1'b0};
                    hint_next = scan_reg;
                end else if (!scan_last) begin
                    scan_next = scan_inc[IDX_W-1:0];
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_next       = out_load ? res_reg : out_reg;
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        pt_reg   <= pt_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

@@ tb/sv/tb_region_table_point_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// tb_region_table_point_lookup_unit
// Self-checking bench for the rectangle table with hinted point lookup.
// A short table of hand-written words walks empty-table lookups, edge-inclusive
// hits, the hint taking priority over lower entries, misses and inverted
// rectangles. Random words then fill the table past its limit while lookups aim
// mostly at stored rectangles, their corners and the points just beside them.
// Each result is compared with its written value or a shadow of table and hint.
// ----------------------------------------------------------------------------
module tb_region_table_point_lookup_unit;
    import rtpl_pkg::*;

    localparam longint LAT_LIM  = 377487360;
    localparam longint LON_LIM  = 754974720;
    localparam int RAND_WORDS   = 400;
    localparam int IDLE_PCT     = 17;
    localparam int CALM_FROM    = 200;     // accepted words with no sender gaps
    localparam int CALM_TO      = 280;
    localparam int RX_CALM_FROM = 3000;    // receiver cycles with no gaps
    localparam int RX_CALM_TO   = 4000;
    localparam int STALL_START  = 1500;    // receiver cycle of the long hold-off
    localparam int STALL_LEN    = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic                    cmd;
        logic signed [LAT_W-1:0] pt_lat;
        logic signed [LON_W-1:0] pt_lon;
        logic signed [LAT_W-1:0] min_lat;
        logic signed [LAT_W-1:0] max_lat;
        logic signed [LON_W-1:0] min_lon;
        logic signed [LON_W-1:0] max_lon;
    } word_t;

    typedef struct {
        word_t   w;
        bit      typed;
        result_t res;
    } dir_row_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic                    s_command      = CMD_APPEND;
    logic signed [LAT_W-1:0] s_point_lat    = '0;
    logic signed [LON_W-1:0] s_point_lon    = '0;
    logic signed [LAT_W-1:0] s_rect_min_lat = '0;
    logic signed [LAT_W-1:0] s_rect_max_lat = '0;
    logic signed [LON_W-1:0] s_rect_min_lon = '0;
    logic signed [LON_W-1:0] s_rect_max_lon = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic                    m_found;
    logic [OUT_IDX_W-1:0]    m_entry_index;
    logic                    m_table_full;

    // shadow of the block's state
    logic [CNT_W-1:0]        shadow_count = '0;
    logic [IDX_W-1:0]        shadow_hint  = '0;
    logic signed [LAT_W-1:0] tbl_min_lat [MAX_ENTRIES];
    logic signed [LAT_W-1:0] tbl_max_lat [MAX_ENTRIES];
    logic signed [LON_W-1:0] tbl_min_lon [MAX_ENTRIES];
    logic signed [LON_W-1:0] tbl_max_lon [MAX_ENTRIES];

    result_t  expected_q [$];
    dir_row_t dir_rows [$];
    word_t    cur;
    bit       cur_typed;
    result_t  cur_res;
    result_t  pred;
    result_t  got_res;
    int       total_words;
    int       words_built;
    int       words_sent;
    int       results_seen;
    int       error_count;
    int       n_hit, n_miss, n_stored, n_refused;
    int       rx_cycles;
    int       cycle_count;
    bit       stim_done;

    region_table_point_lookup_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_point_lat    (s_point_lat),
        .s_point_lon    (s_point_lon),
        .s_rect_min_lat (s_rect_min_lat),
        .s_rect_max_lat (s_rect_max_lat),
        .s_rect_min_lon (s_rect_min_lon),
        .s_rect_max_lon (s_rect_max_lon),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_entry_index  (m_entry_index),
        .m_table_full   (m_table_full)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit encloses_point(input int i, input logic signed [LAT_W-1:0] lat,
                                          input logic signed [LON_W-1:0] lon);
        if (i >= int'(shadow_count))
            return 1'b0;
        return lat >= tbl_min_lat[i] && lat <= tbl_max_lat[i] &&
               lon >= tbl_min_lon[i] && lon <= tbl_max_lon[i];
    endfunction

    // Advance the shadow state by one word and return the result it gives
    function automatic result_t table_response(input word_t w);
        result_t r;
        int      i;
        r = '0;
        if (w.cmd == CMD_APPEND) begin
            if (shadow_count >= MAX_ENTRIES) begin
                r.full = 1'b1;
                n_refused++;
            end else begin
                tbl_min_lat[shadow_count[IDX_W-1:0]] = w.min_lat;
                tbl_max_lat[shadow_count[IDX_W-1:0]] = w.max_lat;
                tbl_min_lon[shadow_count[IDX_W-1:0]] = w.min_lon;
                tbl_max_lon[shadow_count[IDX_W-1:0]] = w.max_lon;
                r.index = shadow_count[OUT_IDX_W-1:0];
                shadow_count++;
                n_stored++;
            end
        end else if (encloses_point(int'(shadow_hint), w.pt_lat, w.pt_lon)) begin
            r.found = 1'b1;
            r.index = shadow_hint;
            n_hit++;
        end else begin
            shadow_hint = '0;
            for (i = 0; i < int'(shadow_count); i++) begin
                if (encloses_point(i, w.pt_lat, w.pt_lon)) begin
                    r.found     = 1'b1;
                    r.index     = i[OUT_IDX_W-1:0];
                    shadow_hint = i[IDX_W-1:0];
                    break;
                end
            end
            if (r.found)
                n_hit++;
            else
                n_miss++;
        end
        return r;
    endfunction

    function automatic longint rand_between(input longint lo, input longint hi);
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    function automatic word_t with_rect(input word_t w, input longint lat_lo, input longint lat_hi,
                                        input longint lon_lo, input longint lon_hi);
        word_t r;
        r         = w;
        r.min_lat = LAT_W'(lat_lo);
        r.max_lat = LAT_W'(lat_hi);
        r.min_lon = LON_W'(lon_lo);
        r.max_lon = LON_W'(lon_hi);
        return r;
    endfunction

    function automatic word_t raw_word();
        word_t w;
        w.cmd     = CMD_APPEND;
        w.pt_lat  = LAT_W'($urandom());
        w.pt_lon  = LON_W'($urandom());
        w.min_lat = LAT_W'($urandom());
        w.max_lat = LAT_W'($urandom());
        w.min_lon = LON_W'($urandom());
        w.max_lon = LON_W'($urandom());
        return w;
    endfunction

    function automatic word_t random_word();
        word_t  w;
        int     pick;
        int     j;
        longint a, b, c, d;
        w    = raw_word();
        pick = $urandom_range(99);
        if (pick < 22) begin
            w.cmd = CMD_APPEND;
            pick  = $urandom_range(99);
            if (pick < 50) begin
                c = longint'($urandom_range(1 << 23));
                d = longint'($urandom_range(1 << 23));
                a = rand_between(-LAT_LIM, LAT_LIM - c);
                b = rand_between(-LON_LIM, LON_LIM - d);
                w = with_rect(w, a, a + c, b, b + d);
            end else if (pick < 65 && shadow_count != 0) begin
                // widen a stored entry so that scan order picks the winner
                j = $urandom_range(int'(shadow_count) - 1);
                w = with_rect(w,
                              longint'(tbl_min_lat[j]) - longint'($urandom_range(1 << 20)),
                              longint'(tbl_max_lat[j]) + longint'($urandom_range(1 << 20)),
                              longint'(tbl_min_lon[j]) - longint'($urandom_range(1 << 20)),
                              longint'(tbl_max_lon[j]) + longint'($urandom_range(1 << 20)));
            end else if (pick < 80) begin
                a = rand_between(-LAT_LIM, LAT_LIM);
                b = rand_between(-LON_LIM, LON_LIM);
                w = with_rect(w, a, rand_between(a, LAT_LIM), b, rand_between(b, LON_LIM));
            end else if (pick < 90) begin
                a = rand_between(-LAT_LIM, LAT_LIM - 1);
                b = rand_between(-LON_LIM, LON_LIM - 1);
                if ($urandom_range(1))
                    w = with_rect(w, rand_between(a + 1, LAT_LIM), a, -LON_LIM, LON_LIM);
                else
                    w = with_rect(w, -LAT_LIM, LAT_LIM, rand_between(b + 1, LON_LIM), b);
            end
        end else begin
            w.cmd = CMD_LOOKUP;
            pick  = $urandom_range(99);
            if (pick < 65 && shadow_count != 0) begin
                j = (pick < 20) ? int'(shadow_hint) : $urandom_range(int'(shadow_count) - 1);
                if (tbl_min_lat[j] <= tbl_max_lat[j] && tbl_min_lon[j] <= tbl_max_lon[j]) begin
                    a = longint'(tbl_min_lat[j]);
                    b = longint'(tbl_max_lat[j]);
                    c = longint'(tbl_min_lon[j]);
                    d = longint'(tbl_max_lon[j]);
                    case ($urandom_range(4))
                        0: begin
                            w.pt_lat = LAT_W'(a);
                            w.pt_lon = LON_W'(c);
                        end
                        1: begin
                            w.pt_lat = LAT_W'(b);
                            w.pt_lon = LON_W'(d);
                        end
                        2: begin
                            w.pt_lat = LAT_W'($urandom_range(1) ? b + 1 : a - 1);
                            w.pt_lon = LON_W'(rand_between(c, d));
                        end
                        3: begin
                            w.pt_lat = LAT_W'(rand_between(a, b));
                            w.pt_lon = LON_W'($urandom_range(1) ? d + 1 : c - 1);
                        end
                        default: begin
                            w.pt_lat = LAT_W'(rand_between(a, b));
                            w.pt_lon = LON_W'(rand_between(c, d));
                        end
                    endcase
                end else begin
                    w.pt_lat = LAT_W'(rand_between(-LAT_LIM, LAT_LIM));
                    w.pt_lon = LON_W'(rand_between(-LON_LIM, LON_LIM));
                end
            end else if (pick < 85) begin
                w.pt_lat = LAT_W'(rand_between(-LAT_LIM, LAT_LIM));
                w.pt_lon = LON_W'(rand_between(-LON_LIM, LON_LIM));
            end
        end
        return w;
    endfunction

    task automatic dir_append(input longint lat_lo, input longint lat_hi, input longint lon_lo,
                              input longint lon_hi, input bit typed, input int idx);
        dir_row_t row;
        row.w         = with_rect(raw_word(), lat_lo, lat_hi, lon_lo, lon_hi);
        row.w.cmd     = CMD_APPEND;
        row.typed     = typed;
        row.res       = '0;
        row.res.index = idx[OUT_IDX_W-1:0];
        dir_rows      = {dir_rows, row};
    endtask

    task automatic dir_lookup(input longint lat, input longint lon, input bit typed,
                              input bit found, input int idx);
        dir_row_t row;
        row.w         = raw_word();
        row.w.cmd     = CMD_LOOKUP;
        row.w.pt_lat  = LAT_W'(lat);
        row.w.pt_lon  = LON_W'(lon);
        row.typed     = typed;
        row.res       = '0;
        row.res.found = found;
        row.res.index = idx[OUT_IDX_W-1:0];
        dir_rows      = {dir_rows, row};
    endtask

    task automatic check_field(input string what, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expv, actv);
            error_count++;
        end
    endtask

    // sender: hold a word until taken, then model it and offer the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pred = table_response(cur);
                if (cur_typed)
                    pred = cur_res;
                expected_q = {expected_q, pred};
                words_sent++;
                stim_done = (words_sent == total_words);
            end
            if (!s_valid || s_ready) begin
                if (words_built < total_words &&
                    ((words_sent >= CALM_FROM && words_sent < CALM_TO) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    if (words_built < dir_rows.size()) begin
                        cur       = dir_rows[words_built].w;
                        cur_typed = dir_rows[words_built].typed;
                        cur_res   = dir_rows[words_built].res;
                    end else begin
                        cur       = random_word();
                        cur_typed = 1'b0;
                    end
                    words_built++;
                    s_command      <= cur.cmd;
                    s_point_lat    <= cur.pt_lat;
                    s_point_lon    <= cur.pt_lon;
                    s_rect_min_lat <= cur.min_lat;
                    s_rect_max_lat <= cur.max_lat;
                    s_rect_min_lon <= cur.min_lon;
                    s_rect_max_lon <= cur.max_lon;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random gaps, one calm stretch and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles >= STALL_START && rx_cycles < STALL_START + STALL_LEN)
                m_ready <= 1'b0;
            else if (rx_cycles >= RX_CALM_FROM && rx_cycles < RX_CALM_TO)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %s %0b %0d %0b",
                         $time, "found/index/full", m_found, m_entry_index, m_table_full);
                error_count++;
            end else begin
                got_res = expected_q.pop_front();
                check_field("found", 32'(got_res.found), 32'(m_found));
                check_field("entry_index", 32'(got_res.index), 32'(m_entry_index));
                check_field("table_full", 32'(got_res.full), 32'(m_table_full));
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d words sent, %0d results pending",
                     $time, cycle_count, words_sent, expected_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        // empty table, centre and a corner of the range
        dir_lookup(0, 0, 1'b1, 1'b0, 0);
        dir_lookup(LAT_LIM, -LON_LIM, 1'b1, 1'b0, 0);
        // small box, inverted box, single point, whole globe
        dir_append(0, 4194304, 0, 4194304, 1'b1, 0);
        dir_append(100, -100, -100, 100, 1'b1, 1);
        dir_append(-1000, -1000, 2000, 2000, 1'b1, 2);
        dir_append(-LAT_LIM, LAT_LIM, -LON_LIM, LON_LIM, 1'b1, 3);
        dir_lookup(0, 0, 1'b1, 1'b1, 0);
        dir_lookup(4194304, 4194304, 1'b1, 1'b1, 0);
        dir_lookup(4194305, 0, 1'b1, 1'b1, 3);
        // hint now on the globe: it wins over entry 0
        dir_lookup(0, 0, 1'b1, 1'b1, 3);
        dir_lookup(-536870912, 0, 1'b1, 1'b0, 0);
        dir_lookup(-1000, 2000, 1'b1, 1'b1, 2);
        dir_lookup(-LAT_LIM, -LON_LIM, 1'b1, 1'b1, 3);
        dir_lookup(LAT_LIM, LON_LIM, 1'b1, 1'b1, 3);
        dir_lookup(536870911, 1073741823, 1'b1, 1'b0, 0);
        dir_lookup(0, -1073741824, 1'b1, 1'b0, 0);
        dir_append(-10, 10, 50, -50, 1'b0, 0);
        dir_append(-LAT_LIM, -LAT_LIM, LON_LIM, LON_LIM, 1'b0, 0);
        dir_lookup(0, 0, 1'b0, 1'b0, 0);
        dir_lookup(0, 60, 1'b0, 1'b0, 0);
        dir_lookup(-LAT_LIM, LON_LIM, 1'b0, 1'b0, 0);
        total_words = dir_rows.size() + RAND_WORDS;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (!stim_done || expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d words: %0d lookup hits, %0d misses, %0d stored, %0d refused as full",
                 words_sent, n_hit, n_miss, n_stored, n_refused);
        $display("Compared %0d result words, %0d mismatches", results_seen, error_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
